FILE: rtl/url_percent_decoder_defines.svh
// Assertion macros shared by the url_percent_decoder RTL.
// Every macro expects aclk and aresetn in scope.
`ifndef URL_PERCENT_DECODER_DEFINES_SVH
`define URL_PERCENT_DECODER_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define UPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Checks that cons holds in the cycle after ante.
`define UPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/upd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upd_pkg
// Types, character constants and helper functions of the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam int unsigned OUT_DEPTH   = 4;
    localparam int unsigned MAX_RESULTS = 3;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam int unsigned LEAD_BIT = 7;

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_LEAD  = 2'd1,
        PH_PCT   = 2'd2,
        PH_PCT1  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       string_end;
    } out_item_t;

    // Outcome of pushing one byte through the plain decoder.
    typedef struct packed {
        phase_t     phase;
        logic       emit;
        logic [7:0] data;
    } feed_t;

    // Value of a hex digit in bits 3:0; bit 4 set means not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF)) begin
            v = {1'b0, c[3:0] + 4'd9};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

    function automatic feed_t feed(input phase_t ph, input logic [7:0] b);
        feed_t f;
        f.phase = PH_PLAIN;
        f.emit  = 1'b0;
        f.data  = b;
        case (ph)
            PH_LEAD: begin
                f.emit = 1'b1;
            end
            PH_PCT: begin
                f.phase = PH_PCT1;
            end
            default: begin
                if (b[LEAD_BIT]) begin
                    f.emit  = 1'b1;
                    f.phase = PH_LEAD;
                end else if (b == CH_PLUS) begin
                    f.emit = 1'b1;
                    f.data = CH_SPACE;
                end else if (b == CH_PCT) begin
                    f.phase = PH_PCT;
                end else begin
                    f.emit = 1'b1;
                end
            end
        endcase
        return f;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/url_percent_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// A decoded result is registered before it leaves the decoder, and the
// decoder takes one encoded byte per cycle in steady state. Each byte yields
// zero to three results, which go into a four-entry result queue drained at
// one result per cycle while m_ready is high; a byte is taken whenever that
// queue holds at most one result, so a malformed escape that expands to three
// results holds the input while the queue drains.
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming URL percent decoder with double-byte lead handling.
// ----------------------------------------------------------------------------
`include "url_percent_decoder_defines.svh"

module url_percent_decoder (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire upd_pkg::in_item_t s_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output upd_pkg::out_item_t     m_item
);

    localparam int unsigned FillW = $clog2(upd_pkg::OUT_DEPTH + 1);
    localparam int unsigned NewW  = $clog2(upd_pkg::MAX_RESULTS + 1);

    upd_pkg::phase_t    phase_reg, phase_next;
    logic [7:0]         held_reg, held_next;
    upd_pkg::out_item_t slots_reg [upd_pkg::OUT_DEPTH];
    upd_pkg::out_item_t slots_next [upd_pkg::OUT_DEPTH];
    logic [FillW-1:0]   fill_reg, fill_next;

    upd_pkg::out_item_t new_items [upd_pkg::MAX_RESULTS];
    logic [NewW-1:0]    new_cnt;

    logic push, pop;
    logic esc_ok;
    logic [FillW-1:0] base;

    assign s_ready = (fill_reg <= FillW'(1));
    assign m_valid = (fill_reg != '0);
    assign m_item  = slots_reg[0];
    assign push    = s_valid && s_ready;
    assign pop     = m_valid && m_ready;

    always_comb begin : esc_check
        logic [4:0] hi_val, lo_val;
        hi_val = upd_pkg::hex_value(held_reg);
        lo_val = upd_pkg::hex_value(s_item.in_byte);
        esc_ok = !hi_val[4] && !lo_val[4] && ({hi_val[3:0], lo_val[3:0]} != 8'h00);
    end

    // Next decoder state.
    always_comb begin : state_next
        upd_pkg::feed_t f_held, f_new;
        upd_pkg::phase_t ph_in;
        f_held = upd_pkg::feed(upd_pkg::PH_PLAIN, held_reg);
        ph_in  = (phase_reg == upd_pkg::PH_PCT1) ? f_held.phase : phase_reg;
        f_new  = upd_pkg::feed(ph_in, s_item.in_byte);
        phase_next = phase_reg;
        held_next  = held_reg;
        if (push) begin
            if (s_item.in_last || (phase_reg == upd_pkg::PH_PCT1 && esc_ok)) begin
                phase_next = upd_pkg::PH_PLAIN;
                held_next  = '0;
            end else begin
                phase_next = f_new.phase;
                held_next  = (ph_in == upd_pkg::PH_PCT) ? s_item.in_byte : 8'h00;
            end
        end
    end

    // Results caused by the byte on the input channel.
    always_comb begin : result_build
        upd_pkg::feed_t  f_held, f_new;
        upd_pkg::phase_t ph_end;
        logic [4:0]      hi_val, lo_val;
        logic [7:0]      bytes [upd_pkg::MAX_RESULTS];
        logic [NewW-1:0] n;
        hi_val = upd_pkg::hex_value(held_reg);
        lo_val = upd_pkg::hex_value(s_item.in_byte);
        n      = '0;
        bytes  = '{default: 8'h00};
        ph_end = upd_pkg::PH_PLAIN;
        f_held = upd_pkg::feed(upd_pkg::PH_PLAIN, held_reg);
        f_new  = '0;
        if (phase_reg == upd_pkg::PH_PCT1) begin
            if (esc_ok) begin
                bytes[n] = {hi_val[3:0], lo_val[3:0]};
                n = n + NewW'(1);
            end else begin
                bytes[n] = upd_pkg::CH_PCT;
                n = n + NewW'(1);
                if (f_held.emit) begin
                    bytes[n] = f_held.data;
                    n = n + NewW'(1);
                end
                f_new = upd_pkg::feed(f_held.phase, s_item.in_byte);
                if (f_new.emit) begin
                    bytes[n] = f_new.data;
                    n = n + NewW'(1);
                end
                ph_end = f_new.phase;
            end
        end else begin
            f_new = upd_pkg::feed(phase_reg, s_item.in_byte);
            if (f_new.emit) begin
                bytes[n] = f_new.data;
                n = n + NewW'(1);
            end
            ph_end = f_new.phase;
        end
        // A percent escape cut short by the end of the string goes out raw.
        if (s_item.in_last) begin
            if (ph_end == upd_pkg::PH_PCT || ph_end == upd_pkg::PH_PCT1) begin
                bytes[n] = upd_pkg::CH_PCT;
                n = n + NewW'(1);
            end
            if (ph_end == upd_pkg::PH_PCT1) begin
                bytes[n] = s_item.in_byte;
                n = n + NewW'(1);
            end
        end
        new_cnt = n;
        for (int k = 0; k < upd_pkg::MAX_RESULTS; k++) begin
            new_items[k].out_byte   = bytes[k];
            new_items[k].run_end    = (NewW'(k + 1) == n);
            new_items[k].string_end = (NewW'(k + 1) == n) && s_item.in_last;
        end
    end

    // Result queue: slot 0 is the head; new results land behind the survivors.
    always_comb begin : queue_next
        logic [FillW-1:0] off;
        base = fill_reg - FillW'(pop);
        for (int i = 0; i < upd_pkg::OUT_DEPTH; i++) begin
            off = FillW'(i) - base;
            slots_next[i] = slots_reg[i];
            if (FillW'(i) < base) begin
                if (pop && i + 1 < upd_pkg::OUT_DEPTH) begin
                    slots_next[i] = slots_reg[(i + 1) % upd_pkg::OUT_DEPTH];
                end
            end else if (push && off < FillW'(new_cnt)) begin
                slots_next[i] = new_items[off[NewW-1:0]];
            end
        end
        fill_next = base + (push ? FillW'(new_cnt) : FillW'(0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= upd_pkg::PH_PLAIN;
            held_reg  <= '0;
            fill_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        slots_reg <= slots_next;
    end

    `UPD_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= FillW'(upd_pkg::OUT_DEPTH),
        "result queue overfilled")
    `UPD_ASSERT_NOW(a_last_has_result, push && s_item.in_last, new_cnt != '0,
        "string end produced no result")
    `UPD_ASSERT_NEXT(a_last_resets, push && s_item.in_last,
        phase_reg == upd_pkg::PH_PLAIN && held_reg == 8'h00,
        "decoder not back in plain text after string end")
    `UPD_ASSERT_NOW(a_held_clear, phase_reg != upd_pkg::PH_PCT1, held_reg == 8'h00,
        "held digit kept outside escape")
    `UPD_ASSERT_NOW(a_end_is_run_end, m_valid && m_item.string_end, m_item.run_end,
        "string end without run end")

endmodule
`default_nettype wire
